// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the IPv4 header checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
	else $error("assertion failed");

`endif

// ----- rtl/core/ipv4hc_pkg.sv -----
// Types, codes and helper functions for the IPv4 header checker.
package ipv4hc_pkg;

	localparam int ADDR_W = 3;

	typedef enum logic [3:0] {
		V_ACCEPT    = 4'd0,
		V_SHORT     = 4'd1,
		V_VERSION   = 4'd2,
		V_HDR_LEN   = 4'd3,
		V_TOTAL_LEN = 4'd4,
		V_FRAGMENT  = 4'd5,
		V_CHECKSUM  = 4'd6,
		V_NOT_OURS  = 4'd7,
		V_PROTOCOL  = 4'd8
	} verdict_t;

	typedef enum logic [1:0] {
		TGT_ICMP = 2'd0,
		TGT_UDP  = 2'd1,
		TGT_TCP  = 2'd2,
		TGT_NONE = 2'd3
	} target_t;

	localparam logic [ADDR_W-1:0] REG_LOCAL_ADDRESS = '0;

	localparam logic [7:0]  PROTO_ICMP    = 8'd1;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [15:0] HDR_MIN_BYTES = 16'd20;
	localparam logic [3:0]  VERSION_IPV4  = 4'd4;
	localparam logic [3:0]  IHL_MIN       = 4'd5;
	localparam logic [15:0] FRAG_MASK     = 16'h3FFF;
	localparam logic [15:0] SUM_GOOD      = 16'hFFFF;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ----- rtl/core/ipv4_header_checker.sv -----
// IPv4 receive header checker: byte stream in, one verdict per packet out.
//
//   channel   handshake                 payload
//   byte      byte_valid / byte_stall   data_byte, last_byte
//   result    result_valid / result_stall
//                                       verdict, target, protocol_number,
//                                       source_address, dest_address,
//                                       header_bytes, payload_bytes
//   config    APB write/read            local_address at paddr 0 to 3
//
// One byte per cycle unless the input stalls. A beat sits in the input
// register, where the header fields and the ones' complement sum are updated;
// a last byte loads the result register. Reset clears the valid flags, count,
// field and sum state and local_address. A stalled result holds only a
// following last byte, which then stalls the input; other bytes flow.
`include "assert_macros.svh"

module ipv4_header_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [3:0]                    verdict,
	output logic [1:0]                    target,
	output logic [7:0]                    protocol_number,
	output logic [31:0]                   source_address,
	output logic [31:0]                   dest_address,
	output logic [5:0]                    header_bytes,
	output logic [15:0]                   payload_bytes,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ipv4hc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import ipv4hc_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        go_s1;
	logic        load_s2;

	logic        valid_s2;
	verdict_t    verdict_s2;
	target_t     target_s2;
	logic [7:0]  proto_s2;
	logic [31:0] src_s2;
	logic [31:0] dst_s2;
	logic [5:0]  hdr_s2;
	logic [15:0] payload_s2;

	logic [31:0] local_address_q;

	logic [15:0] count_q;
	logic [3:0]  version_q;
	logic [3:0]  ihl_q;
	logic [15:0] total_len_q;
	logic [15:0] frag_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [15:0] sum_q;
	logic [7:0]  hold_q;

	logic [15:0] count_n;
	logic [3:0]  version_n;
	logic [3:0]  ihl_n;
	logic [15:0] total_len_n;
	logic [15:0] frag_n;
	logic [7:0]  proto_n;
	logic [31:0] src_n;
	logic [31:0] dst_n;
	logic [15:0] sum_n;
	logic [7:0]  hold_n;
	logic [5:0]  hdr_n;
	logic        in_hdr;

	verdict_t    verdict_c;
	target_t     target_c;
	logic [15:0] payload_c;
	logic        proto_known;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_LOCAL_ADDRESS[ADDR_W-1]) begin
			local_address_q <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1] == REG_LOCAL_ADDRESS[ADDR_W-1]) begin
			prdata = local_address_q;
		end
	end

	// flow control
	assign load_s2    = valid_s1 && last_s1;
	assign go_s1      = valid_s1 && (!last_s1 || !valid_s2 || !result_stall);
	assign byte_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// header field capture and checksum
	always_comb begin
		version_n   = version_q;
		ihl_n       = ihl_q;
		total_len_n = total_len_q;
		frag_n      = frag_q;
		proto_n     = proto_q;
		src_n       = src_q;
		dst_n       = dst_q;
		if (count_q == 16'd0) begin
			version_n = data_s1[7:4];
			ihl_n     = data_s1[3:0];
		end else if (count_q == 16'd2 || count_q == 16'd3) begin
			total_len_n = {total_len_q[7:0], data_s1};
		end else if (count_q == 16'd6 || count_q == 16'd7) begin
			frag_n = {frag_q[7:0], data_s1};
		end else if (count_q == 16'd9) begin
			proto_n = data_s1;
		end else if (count_q >= 16'd12 && count_q <= 16'd15) begin
			src_n = {src_q[23:0], data_s1};
		end else if (count_q >= 16'd16 && count_q <= 16'd19) begin
			dst_n = {dst_q[23:0], data_s1};
		end

		hdr_n  = {ihl_n, 2'b00};
		in_hdr = count_q < {10'd0, hdr_n};
		hold_n = hold_q;
		sum_n  = sum_q;
		if (in_hdr) begin
			if (!count_q[0]) begin
				hold_n = data_s1;
			end else begin
				sum_n = ones_add(sum_q, {hold_q, data_s1});
			end
		end

		count_n = (count_q == COUNT_MAX) ? count_q : count_q + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			version_q   <= '0;
			ihl_q       <= '0;
			total_len_q <= '0;
			frag_q      <= '0;
			proto_q     <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			sum_q       <= '0;
			hold_q      <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				count_q     <= '0;
				version_q   <= '0;
				ihl_q       <= '0;
				total_len_q <= '0;
				frag_q      <= '0;
				proto_q     <= '0;
				src_q       <= '0;
				dst_q       <= '0;
				sum_q       <= '0;
				hold_q      <= '0;
			end else begin
				count_q     <= count_n;
				version_q   <= version_n;
				ihl_q       <= ihl_n;
				total_len_q <= total_len_n;
				frag_q      <= frag_n;
				proto_q     <= proto_n;
				src_q       <= src_n;
				dst_q       <= dst_n;
				sum_q       <= sum_n;
				hold_q      <= hold_n;
			end
		end
	end

	// verdict, first failing check wins
	assign proto_known = (proto_n == PROTO_ICMP) || (proto_n == PROTO_UDP) ||
		(proto_n == PROTO_TCP);

	always_comb begin
		if (count_n < HDR_MIN_BYTES) begin
			verdict_c = V_SHORT;
		end else if (version_n != VERSION_IPV4 || ihl_n < IHL_MIN) begin
			verdict_c = V_VERSION;
		end else if ({10'd0, hdr_n} > count_n) begin
			verdict_c = V_HDR_LEN;
		end else if (total_len_n < {10'd0, hdr_n} || total_len_n > count_n) begin
			verdict_c = V_TOTAL_LEN;
		end else if ((frag_n & FRAG_MASK) != 16'd0) begin
			verdict_c = V_FRAGMENT;
		end else if (sum_n != SUM_GOOD) begin
			verdict_c = V_CHECKSUM;
		end else if (dst_n != local_address_q) begin
			verdict_c = V_NOT_OURS;
		end else if (!proto_known) begin
			verdict_c = V_PROTOCOL;
		end else begin
			verdict_c = V_ACCEPT;
		end

		target_c  = TGT_NONE;
		payload_c = '0;
		if (verdict_c == V_ACCEPT) begin
			case (proto_n)
				PROTO_ICMP: target_c = TGT_ICMP;
				PROTO_UDP:  target_c = TGT_UDP;
				default:    target_c = TGT_TCP;
			endcase
			payload_c = total_len_n - {10'd0, hdr_n};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1 && load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && load_s2) begin
			verdict_s2 <= verdict_c;
			target_s2  <= target_c;
			proto_s2   <= proto_n;
			src_s2     <= src_n;
			dst_s2     <= dst_n;
			hdr_s2     <= hdr_n;
			payload_s2 <= payload_c;
		end
	end

	assign result_valid    = valid_s2;
	assign verdict         = verdict_s2;
	assign target          = target_s2;
	assign protocol_number = proto_s2;
	assign source_address  = src_s2;
	assign dest_address    = dst_s2;
	assign header_bytes    = hdr_s2;
	assign payload_bytes   = payload_s2;

	`ASSERT_CLK(a_last_loads_result, clk, arst_n, go_s1 && last_s1 |=> valid_s2)
	`ASSERT_CLK(a_last_clears_count, clk, arst_n, go_s1 && last_s1 |=> count_q == 16'd0)
	`ASSERT_CLK(a_accept_has_target, clk, arst_n,
		valid_s2 && verdict_s2 == V_ACCEPT |-> target_s2 != TGT_NONE)
	`ASSERT_CLK(a_reject_no_payload, clk, arst_n,
		valid_s2 && verdict_s2 != V_ACCEPT |-> target_s2 == TGT_NONE && payload_s2 == 16'd0)

endmodule

// ----- sim/tb.sv -----
// Testbench for the IPv4 header checker: byte-stream packets in, per-packet verdicts checked.
module tb;
	import ipv4hc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_BYTES = 1050;
	localparam int MAX_REPORTS = 10;
	localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;

	typedef struct {
		verdict_t    verdict;
		target_t     target;
		logic [7:0]  protocol;
		logic [31:0] src;
		logic [31:0] dst;
		logic [5:0]  hdr;
		logic [15:0] payload;
	} ip_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	logic [7:0] data_byte = '0;
	logic last_byte = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [3:0] verdict;
	logic [1:0] target;
	logic [7:0] protocol_number;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [5:0] header_bytes;
	logic [15:0] payload_bytes;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = REG_LOCAL_ADDRESS;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [31:0] own_address;
	logic [15:0] rx_count;
	logic [3:0] rx_version;
	logic [3:0] rx_ihl;
	logic [15:0] rx_total;
	logic [15:0] rx_frag;
	logic [7:0] rx_proto;
	logic [31:0] rx_src;
	logic [31:0] rx_dst;
	logic [15:0] rx_sum;
	logic [7:0] rx_hold;

	ip_verdict_t expected_verdicts[$];
	logic [7:0] pkt_q[$];
	int mismatches = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;

	ipv4_header_checker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.verdict(verdict),
		.target(target),
		.protocol_number(protocol_number),
		.source_address(source_address),
		.dest_address(dest_address),
		.header_bytes(header_bytes),
		.payload_bytes(payload_bytes),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	function automatic void clear_rx_state();
		rx_count = '0;
		rx_version = '0;
		rx_ihl = '0;
		rx_total = '0;
		rx_frag = '0;
		rx_proto = '0;
		rx_src = '0;
		rx_dst = '0;
		rx_sum = '0;
		rx_hold = '0;
	endfunction

	function automatic bit predict_rx_byte(input logic [7:0] b, input bit last,
			output ip_verdict_t r);
		int pos;
		int hdr;
		int len;
		pos = rx_count;
		if (pos == 0) begin
			rx_version = b[7:4];
			rx_ihl = b[3:0];
		end else if (pos == 2 || pos == 3) begin
			rx_total = {rx_total[7:0], b};
		end else if (pos == 6 || pos == 7) begin
			rx_frag = {rx_frag[7:0], b};
		end else if (pos == 9) begin
			rx_proto = b;
		end else if (pos >= 12 && pos <= 15) begin
			rx_src = {rx_src[23:0], b};
		end else if (pos >= 16 && pos <= 19) begin
			rx_dst = {rx_dst[23:0], b};
		end
		if (pos < int'(rx_ihl) * 4) begin
			if (pos % 2 == 0)
				rx_hold = b;
			else
				rx_sum = add_ones(rx_sum, {rx_hold, b});
		end
		if (rx_count != COUNT_MAX)
			rx_count = rx_count + 16'd1;
		if (!last)
			return 1'b0;
		len = rx_count;
		hdr = int'(rx_ihl) * 4;
		if (len < HDR_MIN_BYTES)
			r.verdict = V_SHORT;
		else if (rx_version != VERSION_IPV4 || rx_ihl < IHL_MIN)
			r.verdict = V_VERSION;
		else if (hdr > len)
			r.verdict = V_HDR_LEN;
		else if (int'(rx_total) < hdr || int'(rx_total) > len)
			r.verdict = V_TOTAL_LEN;
		else if ((rx_frag & FRAG_MASK) != 16'd0)
			r.verdict = V_FRAGMENT;
		else if (rx_sum != SUM_GOOD)
			r.verdict = V_CHECKSUM;
		else if (rx_dst != own_address)
			r.verdict = V_NOT_OURS;
		else if (rx_proto != PROTO_ICMP && rx_proto != PROTO_UDP && rx_proto != PROTO_TCP)
			r.verdict = V_PROTOCOL;
		else
			r.verdict = V_ACCEPT;
		r.target = TGT_NONE;
		r.payload = '0;
		if (r.verdict == V_ACCEPT) begin
			if (rx_proto == PROTO_ICMP)
				r.target = TGT_ICMP;
			else if (rx_proto == PROTO_UDP)
				r.target = TGT_UDP;
			else
				r.target = TGT_TCP;
			r.payload = rx_total - 16'(hdr);
		end
		r.protocol = rx_proto;
		r.src = rx_src;
		r.dst = rx_dst;
		r.hdr = 6'(hdr);
		clear_rx_state();
		return 1'b1;
	endfunction

	task automatic check_field(input string what, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%s mismatch: expected %0h, got %0h", what, exp, act);
		end
	endtask

	always @(negedge clk) begin
		result_stall <= !no_gaps && ($urandom_range(99) < 31);
	end

	always @(posedge clk) begin
		ip_verdict_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result with none expected: verdict %0d", verdict);
			end else begin
				e = expected_verdicts.pop_front();
				check_field("verdict", 32'(e.verdict), 32'(verdict));
				check_field("target", 32'(e.target), 32'(target));
				check_field("protocol_number", 32'(e.protocol), 32'(protocol_number));
				check_field("source_address", e.src, source_address);
				check_field("dest_address", e.dst, dest_address);
				check_field("header_bytes", 32'(e.hdr), 32'(header_bytes));
				check_field("payload_bytes", 32'(e.payload), 32'(payload_bytes));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit last);
		ip_verdict_t r;
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 31) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		if (predict_rx_byte(b, last, r))
			expected_verdicts.push_back(r);
		bytes_sent++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt_q.size(); i++)
			send_byte(pkt_q[i], i == pkt_q.size() - 1);
	endtask

	task automatic drain_results();
		@(negedge clk) byte_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Write a register, then read back local_address.
	task automatic set_local_address(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
		drain_results();
		repeat (4) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		if (addr == REG_LOCAL_ADDRESS)
			own_address = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= REG_LOCAL_ADDRESS;
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		check_field("prdata", own_address, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic make_packet(input logic [3:0] ver, input logic [3:0] ihl, input int body,
			input int len_adj, input logic [15:0] frag, input logic [7:0] proto,
			input logic [31:0] src, input logic [31:0] dst);
		int hlen;
		logic [15:0] tot;
		logic [15:0] sum;
		hlen = (ihl < IHL_MIN) ? 20 : int'(ihl) * 4;
		tot = 16'(int'(ihl) * 4 + body + len_adj);
		pkt_q.delete();
		pkt_q.push_back({ver, ihl});
		pkt_q.push_back(8'($urandom));
		pkt_q.push_back(tot[15:8]);
		pkt_q.push_back(tot[7:0]);
		pkt_q.push_back(8'($urandom));
		pkt_q.push_back(8'($urandom));
		pkt_q.push_back(frag[15:8]);
		pkt_q.push_back(frag[7:0]);
		pkt_q.push_back(8'($urandom));
		pkt_q.push_back(proto);
		pkt_q.push_back(8'h00);
		pkt_q.push_back(8'h00);
		for (int i = 3; i >= 0; i--)
			pkt_q.push_back(src[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			pkt_q.push_back(dst[8*i +: 8]);
		for (int i = 20; i < hlen; i++)
			pkt_q.push_back(8'($urandom));
		sum = '0;
		for (int i = 0; i + 1 < int'(ihl) * 4 && i + 1 < pkt_q.size(); i += 2)
			sum = add_ones(sum, {pkt_q[i], pkt_q[i+1]});
		pkt_q[10] = ~sum[15:8];
		pkt_q[11] = ~sum[7:0];
		for (int i = 0; i < body; i++)
			pkt_q.push_back(8'($urandom));
	endtask

	task automatic good_packet(input logic [7:0] proto);
		make_packet(VERSION_IPV4, IHL_MIN, $urandom_range(0, 8), 0, 16'd0, proto, $urandom,
			own_address);
	endtask

	task automatic trim_packet(input int n);
		while (pkt_q.size() > n)
			void'(pkt_q.pop_back());
	endtask

	task automatic test_address_setup();
		set_local_address(REG_LOCAL_ADDRESS, $urandom);
		set_local_address(UNUSED_REG_ADDR, ~own_address);
	endtask

	task automatic test_short_packets();
		pkt_q.delete();
		pkt_q.push_back(8'hFF);
		send_packet();
		good_packet(PROTO_UDP);
		trim_packet(19);
		send_packet();
		good_packet(PROTO_TCP);
		trim_packet(14);
		send_packet();
	endtask

	task automatic test_version_ihl();
		make_packet(4'd6, IHL_MIN, 4, 0, 16'd0, PROTO_UDP, $urandom, own_address);
		send_packet();
		make_packet(VERSION_IPV4, 4'd4, 4, 0, 16'd0, PROTO_UDP, $urandom, own_address);
		send_packet();
		make_packet(4'd0, 4'd0, 4, 0, 16'd0, PROTO_UDP, $urandom, own_address);
		send_packet();
	endtask

	task automatic test_lengths();
		// header claims more bytes than the packet holds
		make_packet(VERSION_IPV4, 4'd15, 0, 0, 16'd0, PROTO_TCP, $urandom, own_address);
		trim_packet(40);
		send_packet();
		make_packet(VERSION_IPV4, IHL_MIN, 10, -12, 16'd0, PROTO_TCP, $urandom, own_address);
		send_packet();
		make_packet(VERSION_IPV4, IHL_MIN, 10, 1, 16'd0, PROTO_TCP, $urandom, own_address);
		send_packet();
		// trailing pad past total length is fine
		make_packet(VERSION_IPV4, IHL_MIN, 10, -4, 16'd0, PROTO_TCP, $urandom, own_address);
		send_packet();
		make_packet(VERSION_IPV4, 4'd15, 3, 0, 16'd0, PROTO_ICMP, $urandom, own_address);
		send_packet();
	endtask

	task automatic test_fragments();
		make_packet(VERSION_IPV4, IHL_MIN, 2, 0, 16'h2000, PROTO_UDP, $urandom, own_address);
		send_packet();
		make_packet(VERSION_IPV4, IHL_MIN, 2, 0, 16'h0001, PROTO_UDP, $urandom, own_address);
		send_packet();
		make_packet(VERSION_IPV4, IHL_MIN, 2, 0, 16'hC000, PROTO_UDP, $urandom, own_address);
		send_packet();
	endtask

	task automatic test_checksum();
		good_packet(PROTO_UDP);
		pkt_q[10] ^= 8'h01;
		send_packet();
		make_packet(VERSION_IPV4, 4'd6, 4, 0, 16'd0, PROTO_UDP, $urandom, own_address);
		pkt_q[22] ^= 8'h80;
		send_packet();
		// bytes past the header stay out of the sum
		make_packet(VERSION_IPV4, IHL_MIN, 4, 0, 16'd0, PROTO_UDP, $urandom, own_address);
		pkt_q[21] ^= 8'hFF;
		send_packet();
	endtask

	task automatic test_destination();
		make_packet(VERSION_IPV4, IHL_MIN, 1, 0, 16'd0, PROTO_ICMP, $urandom,
			own_address ^ 32'd1);
		send_packet();
		set_local_address(REG_LOCAL_ADDRESS, 32'hFFFF_FFFF);
		make_packet(VERSION_IPV4, IHL_MIN, 0, 0, 16'd0, PROTO_ICMP, 32'h0, 32'hFFFF_FFFF);
		send_packet();
		set_local_address(REG_LOCAL_ADDRESS, 32'h0);
		make_packet(VERSION_IPV4, IHL_MIN, 0, 0, 16'd0, PROTO_TCP, 32'hFFFF_FFFF, 32'h0);
		send_packet();
		set_local_address(REG_LOCAL_ADDRESS, $urandom);
	endtask

	task automatic test_protocols();
		good_packet(PROTO_ICMP);
		send_packet();
		good_packet(PROTO_UDP);
		send_packet();
		good_packet(PROTO_TCP);
		send_packet();
		good_packet(8'd0);
		send_packet();
		good_packet(8'd255);
		send_packet();
		good_packet(8'd2);
		send_packet();
	endtask

	task automatic test_random_traffic();
		int pkts;
		int start;
		int kind;
		int body;
		int adj;
		logic [3:0] ver;
		logic [3:0] ihl;
		logic [15:0] frag;
		logic [7:0] proto;
		logic [31:0] dst;
		logic [31:0] addr_plan[3];
		pkts = 0;
		start = bytes_sent;
		addr_plan[0] = 32'hFFFF_FFFF;
		addr_plan[1] = 32'h0;
		addr_plan[2] = $urandom;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if (pkts % 25 == 24)
				set_local_address(REG_LOCAL_ADDRESS, addr_plan[(pkts / 25) % 3]);
			if (pkts == 30)
				drain_results();
			no_gaps = (pkts >= 10 && pkts < 22);
			if ($urandom_range(99) < 85) begin
				kind = ($urandom_range(99) < 30) ? $urandom_range(1, 5) : 0;
				ver = VERSION_IPV4;
				ihl = ($urandom_range(7) == 0) ? 4'($urandom_range(6, 15)) : IHL_MIN;
				body = ($urandom_range(7) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
				adj = 0;
				frag = ($urandom_range(3) == 0) ? {1'($urandom), 1'b1, 14'd0} : 16'd0;
				case ($urandom_range(3))
					0: proto = PROTO_ICMP;
					1: proto = PROTO_UDP;
					2: proto = PROTO_TCP;
					default: proto = 8'($urandom);
				endcase
				dst = ($urandom_range(9) == 0) ? $urandom : own_address;
				case (kind)
					1: adj = $urandom_range(1) ? $urandom_range(1, 8) : -int'($urandom_range(1, 8));
					2: frag |= 16'($urandom_range(1, 16'h3FFF));
					3: if ($urandom_range(1)) ver = 4'($urandom); else ihl = 4'($urandom);
					default: ;
				endcase
				make_packet(ver, ihl, body, adj, frag, proto, $urandom, dst);
				if (kind == 4)
					pkt_q[$urandom_range(19)] ^= 8'($urandom_range(1, 255));
				if (kind == 5)
					trim_packet($urandom_range(1, pkt_q.size() - 1));
			end else begin
				pkt_q.delete();
				repeat ($urandom_range(1, 40)) pkt_q.push_back(8'($urandom));
			end
			send_packet();
			pkts++;
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		own_address = '0;
		clear_rx_state();
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_address_setup();
		test_short_packets();
		test_version_ihl();
		test_lengths();
		test_fragments();
		test_checksum();
		test_destination();
		test_protocols();
		test_random_traffic();
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ipv4hc_pkg.sv
rtl/core/ipv4_header_checker.sv
sim/tb.sv
